>>> sv/uart_frame_receiver_three_mode_top_macros.svh
// Assertion macros for the three-mode frame receiver checker.
// No dependencies; taken in by the checker file.
`ifndef UART_FRAME_RECEIVER_THREE_MODE_TOP_MACROS_SVH
`define UART_FRAME_RECEIVER_THREE_MODE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define UFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ufr_pkg.sv
// Shared types and constants for the three-mode frame receiver.
// No dependencies; used by ufr_step, the top level and the checker.
package ufr_pkg;

  // mode_select codes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_FRAMED = 2'd1;
  localparam logic [1:0] MODE_LINE   = 2'd2;
  localparam logic [1:0] MODE_CHECK  = 2'd3;

  // frame_event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_LINE   = 2'd1;
  localparam logic [1:0] EV_FRAMED = 2'd2;
  localparam logic [1:0] EV_FAULT  = 2'd3;

  // special bytes
  localparam logic [7:0] CH_STX      = 8'h02;
  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] ADDR_MAX    = 8'h05;

  // framed message: STX, header and trailer around the payload
  localparam logic [8:0] FRAME_OVERHEAD = 9'd12;
  // framed message: positions of the two hex length digits
  localparam logic [7:0] POS_LEN_HI = 8'd7;
  localparam logic [7:0] POS_LEN_LO = 8'd8;

  // per-item state carried between words
  typedef struct packed {
    logic [7:0]  fill;
    logic [7:0]  frame_len;
    logic [3:0]  len_hi;
    logic [7:0]  addr_hi;
    logic [7:0]  addr_lo;
    logic        fault_seen;
    logic [1:0]  fault_cnt;
    logic [15:0] fault_addr;
  } ufr_state_t;

  // one result word
  typedef struct packed {
    logic        write_enable;
    logic [7:0]  write_index;
    logic [7:0]  write_byte;
    logic [1:0]  frame_event;
    logic [7:0]  frame_length;
    logic [15:0] fault_address;
  } ufr_result_t;

endpackage

>>> sv/ufr_step.sv
// Single-pass state update for one received byte in all three modes.
// Depends on ufr_pkg for the state and result structs and byte codes.
module ufr_step import ufr_pkg::*; #(
  parameter int BUFFER_DEPTH    = 255,
  parameter int MAX_CHECK_FRAME = 200
) (
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  input  ufr_state_t  cur_i,
  output ufr_state_t  nxt_o,
  output ufr_result_t res_o
);

  localparam logic [7:0] DepthC    = 8'(BUFFER_DEPTH);
  localparam logic [7:0] MaxFrameC = 8'(MAX_CHECK_FRAME);

  // hex digit value, wraps for non-hex bytes
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    digit_value = (b > CH_NINE) ? b - 8'h37 : b - CH_ZERO;
  endfunction

  // uppercase hex character for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? CH_ZERO + {4'h0, n} : 8'h37 + {4'h0, n};
  endfunction

  // true for bytes outside '*'..'9' and 'A'..'F'
  function automatic logic is_visible(input logic [7:0] b);
    is_visible = !((b > 8'h29 && b < 8'h3A) || (b > 8'h40 && b < 8'h47));
  endfunction

  logic [7:0] b;
  logic [7:0] dv;
  logic [8:0] limit;
  logic [7:0] exp_char;
  logic [7:0] sel_addr;
  logic [7:0] slot;
  logic       fault_hit;

  assign b  = rx_byte_i;
  assign dv = digit_value(rx_byte_i);

  always_comb begin
    nxt_o     = cur_i;
    res_o     = '0;
    limit     = '0;
    exp_char  = '0;
    sel_addr  = '0;
    slot      = '0;
    fault_hit = 1'b0;

    case (mode_i)
      // text line: CR skipped, LF ends unstored, '>' ends stored
      MODE_LINE: begin
        if (b == CH_LF || b == CH_GT) begin
          if (b == CH_GT && cur_i.fill < DepthC) begin
            res_o.write_enable = 1'b1;
            res_o.write_index  = cur_i.fill;
            res_o.write_byte   = b;
            nxt_o.fill         = cur_i.fill + 8'd1;
          end
          res_o.frame_event  = EV_LINE;
          res_o.frame_length = nxt_o.fill;
          nxt_o.fill         = '0;
        end else if (b != CH_CR && cur_i.fill < DepthC) begin
          res_o.write_enable = 1'b1;
          res_o.write_index  = cur_i.fill;
          res_o.write_byte   = b;
          nxt_o.fill         = cur_i.fill + 8'd1;
        end
      end

      // framed message with hex length at positions 7 and 8
      MODE_FRAMED: begin
        if ((b >= CH_ZERO && b <= CH_UPPER_F) || b == CH_ETX) begin
          if (cur_i.fill < DepthC) begin
            res_o.write_enable = 1'b1;
            res_o.write_index  = cur_i.fill;
            res_o.write_byte   = b;
            nxt_o.fill         = cur_i.fill + 8'd1;
            if (cur_i.fill == POS_LEN_HI) begin
              nxt_o.len_hi = dv[3:0];
            end else if (cur_i.fill == POS_LEN_LO) begin
              nxt_o.frame_len = {cur_i.len_hi, 4'h0} + dv;
            end
          end
        end else begin
          nxt_o.fill      = '0;
          nxt_o.frame_len = '0;
        end
        limit = {1'b0, nxt_o.frame_len} + FRAME_OVERHEAD;
        if ({1'b0, nxt_o.fill} == limit && b == CH_ETX) begin
          res_o.frame_event  = EV_FRAMED;
          res_o.frame_length = nxt_o.fill;
          nxt_o.fill         = '0;
          nxt_o.frame_len    = '0;
        end else if ({1'b0, nxt_o.fill} > limit) begin
          // overrun
          nxt_o.fill      = '0;
          nxt_o.frame_len = '0;
        end else if (b == CH_STX) begin
          // restart, STX lands at position 0
          res_o.write_enable = 1'b1;
          res_o.write_index  = '0;
          res_o.write_byte   = b;
          nxt_o.fill         = 8'd1;
        end
      end

      // address echo check, reported only when faulty
      MODE_CHECK: begin
        if ((cur_i.fill == MaxFrameC || b == CH_ETX) && cur_i.fill > 8'd3) begin
          if (cur_i.fill < DepthC) begin
            res_o.write_enable = 1'b1;
            res_o.write_index  = cur_i.fill;
            res_o.write_byte   = b;
            nxt_o.fill         = cur_i.fill + 8'd1;
          end
          if (cur_i.fault_seen) begin
            res_o.frame_event   = EV_FAULT;
            res_o.frame_length  = nxt_o.fill;
            res_o.fault_address = cur_i.fault_addr;
          end
          nxt_o.fault_seen = 1'b0;
          nxt_o.fault_cnt  = '0;
          nxt_o.fill       = '0;
        end else if (cur_i.fill == 8'd0) begin
          if (b <= ADDR_MAX) begin
            nxt_o.addr_hi      = b;
            res_o.write_enable = 1'b1;
            res_o.write_index  = '0;
            res_o.write_byte   = b;
            nxt_o.fill         = 8'd1;
          end
        end else if (cur_i.fill == 8'd1) begin
          nxt_o.addr_lo      = b;
          res_o.write_enable = 1'b1;
          res_o.write_index  = 8'd1;
          res_o.write_byte   = b;
          nxt_o.fill         = 8'd2;
        end else if (cur_i.fill == 8'd2) begin
          // expect STX; otherwise shift the address window by one byte
          sel_addr = (b != CH_STX) ? cur_i.addr_lo : cur_i.addr_hi;
          slot     = (b != CH_STX) ? 8'd1 : 8'd2;
          if (sel_addr > ADDR_MAX) begin
            sel_addr = b;
            slot     = '0;
          end
          nxt_o.addr_hi = sel_addr;
          if (sel_addr > ADDR_MAX) begin
            nxt_o.fill = '0;
          end else begin
            if (slot == 8'd1) begin
              nxt_o.addr_lo = b;
            end
            res_o.write_enable = 1'b1;
            res_o.write_index  = slot;
            res_o.write_byte   = b;
            nxt_o.fill         = slot + 8'd1;
          end
        end else begin
          if (cur_i.fill <= 8'd6) begin
            // echoed address characters
            if (cur_i.fill == 8'd3) begin
              exp_char = hex_char(cur_i.addr_hi[7:4]);
            end else if (cur_i.fill == 8'd4) begin
              exp_char = hex_char(cur_i.addr_hi[3:0]);
            end else if (cur_i.fill == 8'd5) begin
              exp_char = hex_char(cur_i.addr_lo[7:4]);
            end else begin
              exp_char = hex_char(cur_i.addr_lo[3:0]);
            end
            fault_hit = (b != exp_char) || cur_i.fault_seen;
          end else begin
            fault_hit = is_visible(b) || cur_i.fault_seen;
          end
          // capture the first offending byte and the byte after it
          if (fault_hit) begin
            nxt_o.fault_seen = 1'b1;
            if (cur_i.fault_cnt == 2'd0) begin
              nxt_o.fault_addr = {b, 8'h00};
              nxt_o.fault_cnt  = 2'd1;
            end else if (cur_i.fault_cnt == 2'd1) begin
              nxt_o.fault_addr = cur_i.fault_addr | {8'h00, b};
              nxt_o.fault_cnt  = 2'd2;
            end
          end
          if (cur_i.fill < DepthC) begin
            res_o.write_enable = 1'b1;
            res_o.write_index  = cur_i.fill;
            res_o.write_byte   = b;
            nxt_o.fill         = cur_i.fill + 8'd1;
          end
        end
      end

      // mode zero: byte ignored
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

>>> sv/uart_frame_receiver_three_mode_top.sv
// An accepted byte waits in the input register and moves to the result register
// when that register is empty or being taken. Throughput: one byte per cycle while
// out_ready_i keeps up, set by the single state-update pass between the registers.
// The result register frees as it is taken, so input and output overlap.
// Reset (rst_ni low, asynchronous) clears state_q and valids, sets mode_select to 3.
// Depends on ufr_pkg and ufr_step.
module uart_frame_receiver_three_mode_top import ufr_pkg::*; #(
  parameter int BUFFER_DEPTH    = 255,
  parameter int MAX_CHECK_FRAME = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  mode_select_i,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_enable_o,
  output logic [7:0]  write_index_o,
  output logic [7:0]  write_byte_o,
  output logic [1:0]  frame_event_o,
  output logic [7:0]  frame_length_o,
  output logic [15:0] fault_address_o
);

  logic [1:0]  mode_q;
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  ufr_result_t res_q;
  ufr_result_t res_d;
  ufr_state_t  state_q;
  ufr_state_t  state_d;
  logic        advance;
  logic        in_fire;

  // held byte moves on when the result register is empty or being taken
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign in_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  ufr_step #(
    .BUFFER_DEPTH   (BUFFER_DEPTH),
    .MAX_CHECK_FRAME(MAX_CHECK_FRAME)
  ) u_step (
    .mode_i   (mode_q),
    .rx_byte_i(in_byte_q),
    .cur_i    (state_q),
    .nxt_o    (state_d),
    .res_o    (res_d)
  );

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CHECK;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= mode_select_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = res_q.write_enable;
  assign write_index_o   = res_q.write_index;
  assign write_byte_o    = res_q.write_byte;
  assign frame_event_o   = res_q.frame_event;
  assign frame_length_o  = res_q.frame_length;
  assign fault_address_o = res_q.fault_address;

endmodule

>>> sv/ufr_checker.sv
// Port-level checker for the three-mode frame receiver, bound to the top.
// Depends on ufr_pkg and uart_frame_receiver_three_mode_top_macros.svh.
`include "uart_frame_receiver_three_mode_top_macros.svh"

module ufr_checker import ufr_pkg::*; #(
  parameter int BUFFER_DEPTH = 255
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_enable_o,
  input logic [7:0]  write_index_o,
  input logic [7:0]  write_byte_o,
  input logic [1:0]  frame_event_o,
  input logic [7:0]  frame_length_o,
  input logic [15:0] fault_address_o
);

  // stores stay inside the buffer
  `UFR_ASSERT_NOW(a_index_in_buffer, clk_i, rst_ni,
    out_valid_o && write_enable_o, write_index_o < 8'(BUFFER_DEPTH),
    "store index beyond buffer end")

  // no store means zero index and byte
  `UFR_ASSERT_NOW(a_idle_write_zero, clk_i, rst_ni,
    out_valid_o && !write_enable_o, write_index_o == 8'h00 && write_byte_o == 8'h00,
    "write fields nonzero without a store")

  // no event means zero length and address
  `UFR_ASSERT_NOW(a_idle_event_zero, clk_i, rst_ni,
    out_valid_o && frame_event_o == EV_NONE,
    frame_length_o == 8'h00 && fault_address_o == 16'h0000,
    "frame fields nonzero without an event")

  // a line that stores its terminator ends on '>' and counts it
  `UFR_ASSERT_NOW(a_line_gt_counted, clk_i, rst_ni,
    out_valid_o && frame_event_o == EV_LINE && write_enable_o,
    write_byte_o == CH_GT && frame_length_o == write_index_o + 8'd1,
    "line end store inconsistent")

  // a stalled result word holds
  `UFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i,
    out_valid_o && $stable(write_index_o) && $stable(frame_event_o)
      && $stable(fault_address_o),
    "result word changed while stalled")

endmodule

bind uart_frame_receiver_three_mode_top ufr_checker #(
  .BUFFER_DEPTH(BUFFER_DEPTH)
) u_ufr_checker (.*);
